@@ rtl/core/vdir_pkg.sv @@
package vdir_pkg;

  // Reset value of the length threshold, Q16.16
  localparam logic [31:0] MIN_LENGTH_RESET = 32'd6;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Differences are one bit wider than the positions
  localparam int DIFF_W = 33;

  // Word passed from the front to the back
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     first_frame;
  } item_t;

endpackage

@@ rtl/core/vdir_front.sv @@
module vdir_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic                  x_invalid,
  input  logic                  y_invalid,
  input  logic                  first_frame,
  input  logic                  q_full,
  output logic                  push,
  output vdir_pkg::item_t       push_item
);
  import vdir_pkg::*;

  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;

  // Invalid components count as zero
  assign cur_x = x_invalid ? 32'sd0 : pos_x;
  assign cur_y = y_invalid ? 32'sd0 : pos_y;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Difference against the previous sample
  always_comb begin
    push_item.dx          = DIFF_W'(cur_x) - DIFF_W'(prev_x);
    push_item.dy          = DIFF_W'(cur_y) - DIFF_W'(prev_y);
    push_item.first_frame = first_frame;
  end

  // Previous sample, updated on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (push) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

endmodule

@@ rtl/core/vdir_queue.sv @@
module vdir_queue #(
  parameter int DEPTH = vdir_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  vdir_pkg::item_t       push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output vdir_pkg::item_t       pop_item
);
  import vdir_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/vdir_back.sv @@
module vdir_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           min_length,
  input  logic                  q_not_empty,
  input  vdir_pkg::item_t       q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    dir_x,
  output logic signed [15:0]    dir_y,
  output logic                  moved
);
  import vdir_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_TEST, S_NORM, S_SQRT, S_DIV, S_OUT
  } state_t;

  state_t       state;
  logic [32:0]  ax, ay;
  logic         negx, negy, ff, phase, is_moved;
  logic [63:0]  thr;
  logic [65:0]  acc;
  logic [33:0]  prod;
  logic [5:0]   psh;
  logic         pv;
  logic [2:0]   k;
  logic [5:0]   cnt;
  logic [31:0]  root;
  logic [34:0]  rem;
  logic [63:0]  rad;
  logic [33:0]  rx, ry;
  logic [14:0]  nlx, nly;
  logic [14:0]  qx, qy;

  // Multiplier operand selection
  logic [16:0]  ma, mb;
  logic [5:0]   msh;
  logic [32:0]  m;
  logic [34:0]  r2, trial;
  logic [46:0]  numx, numy;
  logic [32:0]  dv;
  logic [33:0]  tx, ty;
  logic [32:0]  dxa, dya;

  always_comb begin
    ma = '0; mb = '0; msh = 6'd0;
    case (k)
      3'd0: begin ma = {1'b0, ax[15:0]}; mb = {1'b0, ax[15:0]}; msh = 6'd0; end
      3'd1: begin ma = ax[32:16]; mb = {1'b0, ax[15:0]}; msh = 6'd17; end
      3'd2: begin ma = ax[32:16]; mb = ax[32:16]; msh = 6'd32; end
      3'd3: begin ma = {1'b0, ay[15:0]}; mb = {1'b0, ay[15:0]}; msh = 6'd0; end
      3'd4: begin ma = ay[32:16]; mb = {1'b0, ay[15:0]}; msh = 6'd17; end
      3'd5: begin ma = ay[32:16]; mb = ay[32:16]; msh = 6'd32; end
      default: begin ma = '0; mb = '0; msh = 6'd0; end
    endcase
  end

  // Magnitudes of the incoming differences
  assign dxa = q_item.dx[DIFF_W-1] ? 33'(-q_item.dx) : 33'(q_item.dx);
  assign dya = q_item.dy[DIFF_W-1] ? 33'(-q_item.dy) : 33'(q_item.dy);

  // Larger magnitude for normalisation
  assign m = (ax > ay) ? ax : ay;

  // Square root step
  assign r2    = {rem[32:0], rad[63:62]};
  assign trial = {1'b0, root, 2'b01};

  // Division step
  assign dv = {root, 1'b0};
  assign tx = {rx[32:0], nlx[14]};
  assign ty = {ry[32:0], nly[14]};
  assign numx = {ax[31:0], 15'd0} + {15'd0, root};
  assign numy = {ay[31:0], 15'd0} + {15'd0, root};

  assign pop = (state == S_IDLE) && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      case (state)
        // Take the next word from the queue
        S_IDLE: begin
          if (q_not_empty) begin
            ax    <= dxa;
            ay    <= dya;
            negx  <= q_item.dx[DIFF_W-1];
            negy  <= q_item.dy[DIFF_W-1];
            ff    <= q_item.first_frame;
            thr   <= 64'(min_length) * 64'(min_length);
            acc   <= '0;
            k     <= '0;
            pv    <= 1'b0;
            phase <= 1'b0;
            state <= S_MUL;
          end
        end
        // Sum of squares from 17x17 partial products
        S_MUL: begin
          if (pv) begin
            acc <= acc + ({32'd0, prod} << psh);
          end
          if (k != 3'd6) begin
            prod <= {17'd0, ma} * {17'd0, mb};
            psh  <= msh;
            pv   <= 1'b1;
            k    <= k + 1'b1;
          end else begin
            pv <= 1'b0;
            if (!phase) begin
              state <= S_TEST;
            end else begin
              state <= S_SQRT;
              cnt   <= '0;
              root  <= '0;
              rem   <= '0;
            end
          end
        end
        // Exact threshold test on squared length; a first frame reports no motion
        S_TEST: begin
          if (!ff && (acc > {2'b00, thr})) begin
            is_moved <= 1'b1;
            state    <= S_NORM;
          end else begin
            is_moved <= 1'b0;
            qx       <= '0;
            qy       <= '0;
            state    <= S_OUT;
          end
        end
        // Bring the larger magnitude into [2^30, 2^31)
        S_NORM: begin
          if (m[32] || m[31]) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else if (m[30:23] == '0) begin
            ax <= ax << 8;
            ay <= ay << 8;
          end else if (m[30:27] == '0) begin
            ax <= ax << 4;
            ay <= ay << 4;
          end else if (m[30:29] == '0) begin
            ax <= ax << 2;
            ay <= ay << 2;
          end else if (!m[30]) begin
            ax <= ax << 1;
            ay <= ay << 1;
          end else begin
            acc   <= '0;
            k     <= '0;
            pv    <= 1'b0;
            phase <= 1'b1;
            state <= S_MUL;
          end
        end
        // Integer square root, one result bit a cycle, 32 bits
        S_SQRT: begin
          if (cnt == '0) begin
            rad <= acc[63:0];
            cnt <= 6'd1;
          end else begin
            rad <= rad << 2;
            if (r2 >= trial) begin
              rem  <= r2 - trial;
              root <= {root[30:0], 1'b1};
            end else begin
              rem  <= r2;
              root <= {root[30:0], 1'b0};
            end
            if (cnt == 6'd32) begin
              cnt   <= '0;
              qx    <= '0;
              qy    <= '0;
              state <= S_DIV;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        // Rounded quotients, both components side by side
        S_DIV: begin
          if (cnt == '0) begin
            rx  <= {2'b00, numx[46:15]};
            ry  <= {2'b00, numy[46:15]};
            nlx <= numx[14:0];
            nly <= numy[14:0];
            cnt <= 6'd1;
          end else begin
            nlx <= nlx << 1;
            nly <= nly << 1;
            if (tx >= {1'b0, dv}) begin
              rx <= tx - {1'b0, dv};
              qx <= {qx[13:0], 1'b1};
            end else begin
              rx <= tx;
              qx <= {qx[13:0], 1'b0};
            end
            if (ty >= {1'b0, dv}) begin
              ry <= ty - {1'b0, dv};
              qy <= {qy[13:0], 1'b1};
            end else begin
              ry <= ty;
              qy <= {qy[13:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
            if (cnt == 6'd15) begin
              state <= S_OUT;
            end
          end
        end
        // Hand the result to the output register
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            dir_x <= negx ? 16'(-{1'b0, qx}) : {1'b0, qx};
            dir_y <= negy ? 16'(-{1'b0, qy}) : {1'b0, qy};
            moved <= is_moved;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Output word register
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/velocity_direction_from_positions_unit.sv @@
// Unit direction of motion from a stream of 2D positions.
// Input channel: in_valid / in_stall with pos_x, pos_y (signed Q16.16),
// x_invalid, y_invalid and first_frame. Invalid components count as zero.
// Output channel: out_valid / out_stall with dir_x, dir_y (signed Q2.14)
// and moved. One result word for every input word, in order.
// Config channel: cfg_valid / cfg_ready with cfg_data, the Q16.16 length
// threshold; cfg_ready is always high. Write it only while the block is idle.
// The front takes a word while the queue is not full, forms the difference
// against the previous sample and places it in a short queue. The back
// handles one word at a time: a pass of partial products and the threshold
// test, and, when a direction is computed, normalisation, a second pass of
// partial products, the bit-serial square root and the 15-step divider.
// Reset clears the previous sample to zero, empties the queue and sets the
// threshold to 6 LSB. A result waits in the output register while out_stall
// is high; the front keeps taking words until the queue fills.
module velocity_direction_from_positions_unit #(
  parameter int QUEUE_DEPTH = vdir_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic               x_invalid,
  input  logic               y_invalid,
  input  logic               first_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic               moved,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import vdir_pkg::*;

  logic        q_full, q_not_empty, push, pop;
  item_t       push_item, pop_item;
  logic [31:0] min_length;

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_length <= cfg_data;
    end
  end

  vdir_front u_front (
    .clk, .rst, .in_valid, .in_stall, .pos_x, .pos_y, .x_invalid, .y_invalid,
    .first_frame, .q_full, .push, .push_item
  );

  vdir_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_item, .full(q_full), .pop,
    .not_empty(q_not_empty), .pop_item
  );

  vdir_back u_back (
    .clk, .rst, .min_length, .q_not_empty, .q_item(pop_item), .pop,
    .out_valid, .out_stall, .dir_x, .dir_y, .moved
  );

endmodule
